// ===== design/ttip_pkg.sv =====
`timescale 1ns / 1ps

package ttip_pkg;

	// Datapath widths.
	localparam int VALUE_W  = 64;
	localparam int OFFSET_W = 16;
	localparam int RADIX_W  = 6;
	localparam int DIGIT_W  = 6;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Radix values.
	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

	// Digit code for a byte that is no digit at all.
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

	// Character codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [DIGIT_W-1:0]  digit;
		logic                is_space;
		logic                is_plus;
		logic                is_minus;
		logic                is_zero;
		logic                is_x;
		logic                first;
		logic [RADIX_W-1:0]  radix;
		logic                uns;
		logic [OFFSET_W-1:0] pos;
		logic                last;
	} ttip_item_t;

	// Value of a digit character, or DIGIT_NONE for anything else.
	function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd36;
			if (c >= CH_0 && c <= CH_9) begin
				t = c - CH_0;
			end else if (c >= CH_UA && c <= CH_UZ) begin
				t = c - CH_UA + 8'd10;
			end else if (c >= CH_LA && c <= CH_LZ) begin
				t = c - CH_LA + 8'd10;
			end
			return t[DIGIT_W-1:0];
		end
	endfunction

endpackage

// ===== design/ttip_front.sv =====
`timescale 1ns / 1ps

module ttip_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        q_full,
	input  logic [7:0]                  char_code,
	input  logic [ttip_pkg::RADIX_W-1:0] radix,
	input  logic                        unsigned_mode,
	input  logic                        last,
	output logic                        q_push,
	output ttip_pkg::ttip_item_t        q_item
);
	import ttip_pkg::*;

	logic [OFFSET_W-1:0] pos_q;
	logic [RADIX_W-1:0]  radix_q;
	logic                uns_q;
	logic                first;
	logic [RADIX_W-1:0]  radix_eff;
	logic                uns_eff;
	logic [OFFSET_W-1:0] pos_after;

	assign q_push = push && !q_full;

	// The radix and mode are sampled on the first byte of a string.
	assign first     = (pos_q == '0);
	assign radix_eff = first ? ((radix > RADIX_MAX) ? RADIX_MAX : radix) : radix_q;
	assign uns_eff   = first ? unsigned_mode : uns_q;
	assign pos_after = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	// Classify the byte.
	always_comb begin
		q_item          = '0;
		q_item.digit    = digit_value(char_code);
		q_item.is_space = (char_code == CH_SPACE) ||
			(char_code >= CH_TAB && char_code <= CH_CR);
		q_item.is_plus  = (char_code == CH_PLUS);
		q_item.is_minus = (char_code == CH_MINUS);
		q_item.is_zero  = (char_code == CH_0);
		q_item.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
		q_item.first    = first;
		q_item.radix    = radix_eff;
		q_item.uns      = uns_eff;
		q_item.pos      = pos_after;
		q_item.last     = last;
	end

	// Byte position and sampled settings of the current string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			radix_q <= '0;
			uns_q   <= 1'b0;
		end else if (q_push) begin
			pos_q   <= last ? '0 : pos_after;
			radix_q <= radix_eff;
			uns_q   <= uns_eff;
		end
	end

endmodule

// ===== design/ttip_queue.sv =====
`timescale 1ns / 1ps

module ttip_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  ttip_pkg::ttip_item_t         wr_item,
	input  logic                         rd_en,
	output ttip_pkg::ttip_item_t         rd_item,
	output logic                         full,
	output logic                         empty,
	output logic [ttip_pkg::Q_CNT_W-1:0] count
);
	import ttip_pkg::*;

	ttip_item_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Storage for the waiting items.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/ttip_back.sv =====
`timescale 1ns / 1ps

module ttip_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  ttip_pkg::ttip_item_t          q_item,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [ttip_pkg::VALUE_W-1:0]  value,
	output logic [ttip_pkg::OFFSET_W-1:0] end_offset,
	output logic                          range_error
);
	import ttip_pkg::*;

	localparam int PROD_W = VALUE_W + RADIX_W + 1;

	typedef enum logic [4:0] {
		PH_SKIP   = 5'b00001,
		PH_SIGN   = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_DONE   = 5'b10000
	} ttip_phase_t;

	ttip_phase_t         phase_q, phase_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;
	logic                neg_q, neg_d;
	logic                ovf_q, ovf_d;
	logic [RADIX_W-1:0]  active_q, active_d;
	logic [OFFSET_W-1:0] stop_q, stop_d;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                rerr_q;

	logic                fire;
	logic [RADIX_W-1:0]  rb;
	logic                zero_prefix;
	logic                take_digit;
	logic [RADIX_W-1:0]  r_use;
	logic [VALUE_W-1:0]  lim;
	logic [PROD_W-1:0]   sum;
	logic                too_big;
	logic [VALUE_W-1:0]  result;

	// A last byte waits until the result register is free.
	assign fire  = !q_empty && (!q_item.last || !out_valid_q || pop);
	assign q_pop = fire;

	assign rb          = q_item.first ? q_item.radix : active_q;
	assign zero_prefix = q_item.is_zero && (rb == RADIX_AUTO || rb == RADIX_HEX);

	// Pick the radix that the byte is weighed in, if it is weighed at all.
	always_comb begin
		take_digit = 1'b0;
		r_use      = rb;
		case (phase_q)
			PH_SKIP: begin
				if (!q_item.is_space && !q_item.is_plus && !q_item.is_minus && !zero_prefix) begin
					take_digit = 1'b1;
					r_use      = (rb == RADIX_AUTO) ? RADIX_DEC : rb;
				end
			end
			PH_SIGN: begin
				if (!zero_prefix) begin
					take_digit = 1'b1;
					r_use      = (rb == RADIX_AUTO) ? RADIX_DEC : rb;
				end
			end
			PH_ZERO: begin
				if (!q_item.is_x) begin
					take_digit = 1'b1;
					r_use      = (rb == RADIX_AUTO) ? RADIX_OCT : rb;
				end
			end
			PH_DIGITS: begin
				take_digit = 1'b1;
			end
			default: begin
				take_digit = 1'b0;
			end
		endcase
	end

	// Multiply-accumulate with the overflow check against the mode's limit.
	assign lim = q_item.uns ? {VALUE_W{1'b1}} :
		({1'b0, {(VALUE_W-1){1'b1}}} + VALUE_W'(neg_q));
	assign sum = (PROD_W'(acc_q) * PROD_W'(r_use)) + PROD_W'(q_item.digit);
	assign too_big = (sum > PROD_W'(lim));

	// Next state of the string.
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		ovf_d    = ovf_q;
		active_d = rb;
		stop_d   = stop_q;
		case (phase_q)
			PH_SKIP: begin
				if (q_item.is_space) begin
					phase_d = PH_SKIP;
				end else if (q_item.is_plus || q_item.is_minus) begin
					neg_d   = q_item.is_minus;
					phase_d = PH_SIGN;
				end else if (zero_prefix) begin
					acc_d   = '0;
					stop_d  = q_item.pos;
					phase_d = PH_ZERO;
				end
			end
			PH_SIGN: begin
				if (zero_prefix) begin
					acc_d   = '0;
					stop_d  = q_item.pos;
					phase_d = PH_ZERO;
				end
			end
			PH_ZERO: begin
				if (q_item.is_x) begin
					active_d = RADIX_HEX;
					stop_d   = q_item.pos;
					phase_d  = PH_DIGITS;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		// A byte weighed as a digit either ends the number or extends it.
		if (take_digit) begin
			active_d = r_use;
			if (r_use == RADIX_AUTO || q_item.digit >= r_use) begin
				phase_d = PH_DONE;
			end else begin
				if (!ovf_q) begin
					if (too_big) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = sum[VALUE_W-1:0];
					end
				end
				stop_d  = q_item.pos;
				phase_d = PH_DIGITS;
			end
		end
	end

	// Final value: saturated on overflow, otherwise the signed magnitude.
	always_comb begin
		if (ovf_d) begin
			if (q_item.uns) begin
				result = {VALUE_W{1'b1}};
			end else if (neg_d) begin
				result = {1'b1, {(VALUE_W-1){1'b0}}};
			end else begin
				result = {1'b0, {(VALUE_W-1){1'b1}}};
			end
		end else begin
			result = neg_d ? ('0 - acc_d) : acc_d;
		end
	end

	// String state; a last byte returns it to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			active_q <= '0;
			stop_q   <= '0;
		end else if (fire) begin
			if (q_item.last) begin
				phase_q  <= PH_SKIP;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				ovf_q    <= 1'b0;
				active_q <= '0;
				stop_q   <= '0;
			end else begin
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				neg_q    <= neg_d;
				ovf_q    <= ovf_d;
				active_q <= active_d;
				stop_q   <= stop_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && q_item.last) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && q_item.last) begin
			value_q  <= result;
			offset_q <= stop_d;
			rerr_q   <= ovf_d;
		end
	end

	assign empty       = !out_valid_q;
	assign value       = value_q;
	assign end_offset  = offset_q;
	assign range_error = rerr_q;

endmodule

// ===== design/text_to_integer_parser.sv =====
`timescale 1ns / 1ps

// Parses one string, fed a byte per item with last set on the final byte,
// like strtol or strtoul: leading whitespace, an optional sign, a 0x prefix
// or a leading 0 in automatic radix, then digits into a 64-bit value with
// sticky overflow. The radix and mode are sampled on the first byte. Each
// string gives one result: the value, the offset where parsing stopped and
// a range flag. The block takes one byte per cycle while the queue is not
// full; the front classifies the byte and a four-entry queue feeds the
// back, which folds one byte a cycle into the accumulator with one multiply
// by the radix. A result waits in a single output register, so a last byte
// stalls in the queue only while the previous result has not been popped; a
// last byte passes the queue and the result register to the result ports.
module text_to_integer_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    char_code,
	input  logic [ttip_pkg::RADIX_W-1:0]  radix,
	input  logic                          unsigned_mode,
	input  logic                          last,
	output logic                          empty,
	input  logic                          pop,
	output logic [ttip_pkg::VALUE_W-1:0]  value,
	output logic [ttip_pkg::OFFSET_W-1:0] end_offset,
	output logic                          range_error
);
	import ttip_pkg::*;

	ttip_item_t         f_item;
	ttip_item_t         b_item;
	logic               f_push;
	logic               b_pop;
	logic               q_empty;
	logic [Q_CNT_W-1:0] q_count;

	// Front: sampling and classification of each byte.
	ttip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_full        (full),
		.char_code     (char_code),
		.radix         (radix),
		.unsigned_mode (unsigned_mode),
		.last          (last),
		.q_push        (f_push),
		.q_item        (f_item)
	);

	// Queue between the two halves.
	ttip_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_item (f_item),
		.rd_en   (b_pop),
		.rd_item (b_item),
		.full    (full),
		.empty   (q_empty),
		.count   (q_count)
	);

	// Back: parse state, accumulator and result register.
	ttip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (b_item),
		.q_pop       (b_pop),
		.pop         (pop),
		.empty       (empty),
		.value       (value),
		.end_offset  (end_offset),
		.range_error (range_error)
	);

	// The queue never holds more items than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count above its depth");

	// A range error always comes with one of the saturation values.
	a_range_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && range_error) |->
			(value == {VALUE_W{1'b1}} ||
			 value == {1'b1, {(VALUE_W-1){1'b0}}} ||
			 value == {1'b0, {(VALUE_W-1){1'b1}}}))
		else $error("range error without a saturated value");

	// The queue only drains while it holds items.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |-> !q_empty)
		else $error("back took an item from an empty queue");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ttip_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int ITEMS_PER_PHASE = 335;
	localparam int HOLD_AT_RESULT  = 20;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 16;
	localparam int REPORT_LIMIT    = 10;
	localparam logic [OFFSET_W-1:0] POS_MAX = '1;

	// Idle percentages of the sender and the receiver, one entry per phase.
	localparam int SEND_IDLE [4] = '{0, 66, 0, 10};
	localparam int RECV_STALL [4] = '{0, 0, 66, 10};

	typedef enum logic [4:0] {
		SCAN_SKIP   = 5'b00001,
		SCAN_SIGN   = 5'b00010,
		SCAN_ZERO   = 5'b00100,
		SCAN_DIGITS = 5'b01000,
		SCAN_DONE   = 5'b10000
	} scan_phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic                range_err;
	} parse_result_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic [RADIX_W-1:0] rdx;
		logic               uns;
		logic               lst;
		logic               typed;
		parse_result_t      res;
	} stim_row_t;

	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	// Directed strings; the last byte of each carries the result it must give.
	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{CH_0 + 8'd7, RADIX_DEC, 1'b0, 1'b1, 1'b1, '{64'd7, 16'd1, 1'b0}},
		'{CH_0, RADIX_AUTO, 1'b0, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LX, RADIX_AUTO, 1'b0, 1'b1, 1'b1, '{64'd0, 16'd2, 1'b0}},
		'{CH_PLUS, RADIX_DEC, 1'b0, 1'b1, 1'b1, '{64'd0, 16'd0, 1'b0}},
		'{8'hFF, RADIX_HEX, 1'b1, 1'b1, 1'b1, '{64'd0, 16'd0, 1'b0}},
		'{CH_0, 6'd1, 1'b0, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_0 + 8'd1, 6'd1, 1'b0, 1'b1, 1'b1, '{64'd0, 16'd1, 1'b0}},
		'{CH_0, RADIX_AUTO, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_0 + 8'd8, RADIX_AUTO, 1'b1, 1'b1, 1'b1, '{64'd0, 16'd1, 1'b0}},
		'{CH_TAB, 6'd63, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_MINUS, 6'd63, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_0 + 8'd1, 6'd63, 1'b1, 1'b1, 1'b1, '{ALL_ONES, 16'd3, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b0, 1'b0, '{64'd0, 16'd0, 1'b0}},
		'{CH_LZ, RADIX_MAX, 1'b1, 1'b1, 1'b1, '{ALL_ONES, 16'd13, 1'b1}}
	};

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [7:0]          char_code;
	logic [RADIX_W-1:0]  radix;
	logic                unsigned_mode;
	logic                last;
	logic                empty;
	logic                pop;
	logic [VALUE_W-1:0]  value;
	logic [OFFSET_W-1:0] end_offset;
	logic                range_error;

	text_to_integer_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.radix         (radix),
		.unsigned_mode (unsigned_mode),
		.last          (last),
		.empty         (empty),
		.pop           (pop),
		.value         (value),
		.end_offset    (end_offset),
		.range_error   (range_error)
	);

	// Scanner state of the predictor.
	scan_phase_t         scan_phase;
	logic [VALUE_W-1:0]  scan_acc;
	logic                scan_neg;
	logic                scan_ovf;
	logic [RADIX_W-1:0]  scan_radix;
	logic                scan_uns;
	logic [OFFSET_W-1:0] scan_pos;
	logic [OFFSET_W-1:0] scan_stop;

	parse_result_t parse_results_due [$];
	int            send_idle_pct;
	int            recv_stall_pct;
	int            results_seen;
	int            err_count;
	int            cycle_count;
	bit            held;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_phase = SCAN_SKIP;
		scan_acc   = '0;
		scan_neg   = 1'b0;
		scan_ovf   = 1'b0;
		scan_radix = RADIX_AUTO;
		scan_uns   = 1'b0;
		scan_pos   = '0;
		scan_stop  = '0;
	endfunction

	function automatic logic [DIGIT_W-1:0] char_digit(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) begin
			return DIGIT_W'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			return DIGIT_W'(c - CH_UA + 8'd10);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			return DIGIT_W'(c - CH_LA + 8'd10);
		end
		return DIGIT_NONE;
	endfunction

	// Folds one digit into the accumulator, or stops the scan on a non-digit.
	function automatic void take_digit(input logic [7:0] c, input logic [OFFSET_W-1:0] np);
		logic [DIGIT_W-1:0] d;
		logic [VALUE_W-1:0] lim;
		d = char_digit(c);
		if (scan_radix == RADIX_AUTO || d >= scan_radix) begin
			scan_phase = SCAN_DONE;
			return;
		end
		if (!scan_ovf) begin
			lim = scan_uns ? ALL_ONES : ((ALL_ONES >> 1) + VALUE_W'(scan_neg));
			if (scan_acc > (lim - VALUE_W'(d)) / VALUE_W'(scan_radix)) begin
				scan_ovf = 1'b1;
			end else begin
				scan_acc = scan_acc * VALUE_W'(scan_radix) + VALUE_W'(d);
			end
		end
		scan_stop  = np;
		scan_phase = SCAN_DIGITS;
	endfunction

	// First character after blanks and sign: a zero may open a prefix.
	function automatic void take_first(input logic [7:0] c, input logic [OFFSET_W-1:0] np);
		if (c == CH_0 && (scan_radix == RADIX_AUTO || scan_radix == RADIX_HEX)) begin
			scan_acc   = '0;
			scan_stop  = np;
			scan_phase = SCAN_ZERO;
		end else begin
			if (scan_radix == RADIX_AUTO) begin
				scan_radix = RADIX_DEC;
			end
			take_digit(c, np);
		end
	endfunction

	// Predicts the block for one accepted item; returns 1 when it ends a string.
	function automatic bit fold_byte(input logic [7:0] c, input logic [RADIX_W-1:0] r,
			input logic u, input logic l, output parse_result_t res);
		logic [OFFSET_W-1:0] np;
		res = '0;
		if (scan_pos == '0) begin
			scan_radix = (r > RADIX_MAX) ? RADIX_MAX : r;
			scan_uns   = u;
		end
		np = (scan_pos != POS_MAX) ? scan_pos + 1'b1 : scan_pos;
		case (scan_phase)
			SCAN_SKIP: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					scan_neg   = (c == CH_MINUS);
					scan_phase = SCAN_SIGN;
				end else begin
					take_first(c, np);
				end
			end
			SCAN_SIGN: begin
				take_first(c, np);
			end
			SCAN_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					scan_radix = RADIX_HEX;
					scan_stop  = np;
					scan_phase = SCAN_DIGITS;
				end else begin
					if (scan_radix == RADIX_AUTO) begin
						scan_radix = RADIX_OCT;
					end
					take_digit(c, np);
				end
			end
			SCAN_DIGITS: begin
				take_digit(c, np);
			end
			default: begin
			end
		endcase
		scan_pos = np;
		if (!l) begin
			return 1'b0;
		end
		if (scan_ovf) begin
			if (scan_uns) begin
				res.value = ALL_ONES;
			end else if (scan_neg) begin
				res.value = (ALL_ONES >> 1) + 1'b1;
			end else begin
				res.value = ALL_ONES >> 1;
			end
		end else begin
			res.value = scan_neg ? -scan_acc : scan_acc;
		end
		res.offset    = scan_stop;
		res.range_err = scan_ovf;
		clear_scan();
		return 1'b1;
	endfunction

	// Offers one item after a random gap and waits until it is taken.
	task automatic send_byte(input logic [7:0] c, input logic [RADIX_W-1:0] r, input logic u,
			input logic l, input bit typed, input parse_result_t typed_res);
		parse_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		char_code     <= c;
		radix         <= r;
		unsigned_mode <= u;
		last          <= l;
		do @(posedge clk); while (full);
		if (fold_byte(c, r, u, l, res)) begin
			parse_results_due.push_back(typed ? typed_res : res);
		end
	endtask

	// Builds one random string, mostly well-formed numbers, and sends it.
	task automatic send_string(output int n_sent);
		logic [7:0]         txt [$];
		logic [7:0]         digs [$];
		logic [7:0]         ch;
		logic [RADIX_W-1:0] r;
		logic               u;
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] base;
		int                 dv;
		int                 k;
		case ($urandom_range(9))
			0: r = RADIX_AUTO;
			1: r = 6'd2;
			2: r = RADIX_OCT;
			3: r = RADIX_DEC;
			4: r = RADIX_HEX;
			5: r = RADIX_MAX;
			6: r = 6'd1;
			default: r = 6'($urandom_range(63));
		endcase
		u = 1'($urandom_range(1));
		if ($urandom_range(99) < 15) begin
			// Noise: arbitrary bytes.
			repeat ($urandom_range(6, 1)) txt.push_back(8'($urandom_range(255)));
		end else begin
			k = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
			repeat (k) begin
				txt.push_back(($urandom_range(4) == 0) ? CH_SPACE : 8'($urandom_range(13, 9)));
			end
			case ($urandom_range(2))
				0: txt.push_back(CH_PLUS);
				1: txt.push_back(CH_MINUS);
				default: begin
				end
			endcase
			base = VALUE_W'((r > RADIX_MAX) ? RADIX_MAX : r);
			if (r == RADIX_AUTO) begin
				case ($urandom_range(2))
					0: begin
						txt.push_back(CH_0);
						txt.push_back($urandom_range(1) ? CH_LX : CH_UX);
						base = VALUE_W'(RADIX_HEX);
					end
					1: begin
						txt.push_back(CH_0);
						base = VALUE_W'(RADIX_OCT);
					end
					default: base = VALUE_W'(RADIX_DEC);
				endcase
			end else if (r == RADIX_HEX && $urandom_range(3) == 0) begin
				txt.push_back(CH_0);
				txt.push_back($urandom_range(1) ? CH_LX : CH_UX);
			end
			if (base < 2) begin
				repeat ($urandom_range(8)) txt.push_back(CH_0);
			end else if ($urandom_range(19) != 0) begin
				// Magnitudes cluster around the signed and unsigned limits.
				case ($urandom_range(9))
					0, 1, 2: mag = VALUE_W'($urandom_range(999));
					3: mag = {$urandom, $urandom};
					4, 5: mag = (ALL_ONES >> 1) + VALUE_W'($urandom_range(2));
					6: mag = ALL_ONES - VALUE_W'($urandom_range(2));
					default: mag = {$urandom, $urandom} >> $urandom_range(63);
				endcase
				do begin
					dv = int'(mag % base);
					if (dv < 10) begin
						ch = CH_0 + 8'(dv);
					end else begin
						ch = ($urandom_range(1) ? CH_UA : CH_LA) + 8'(dv - 10);
					end
					digs.push_front(ch);
					mag = mag / base;
				end while (mag != 0);
				if ($urandom_range(9) == 0) begin
					digs.push_back(CH_0 + 8'($urandom_range(int'(base) > 10 ? 9 : int'(base) - 1)));
				end
				txt = {txt, digs};
			end
			if ($urandom_range(9) < 3) begin
				repeat ($urandom_range(3, 1)) txt.push_back(8'($urandom_range(255)));
			end
		end
		if (txt.size() == 0) begin
			txt.push_back(8'($urandom_range(255)));
		end
		// Radix and mode of later bytes are ignored by the block, so they are random.
		for (k = 0; k < txt.size(); k++) begin
			send_byte(txt[k], (k == 0) ? r : 6'($urandom_range(63)),
				(k == 0) ? u : 1'($urandom_range(1)), k == txt.size() - 1, 1'b0, '0);
		end
		n_sent = txt.size();
	endtask

	// Compares one accepted result with the oldest prediction.
	task automatic check_result();
		parse_result_t exp;
		results_seen++;
		if (parse_results_due.size() == 0) begin
			err_count++;
			if (err_count <= REPORT_LIMIT) begin
				$display("result %0d arrived with nothing expected: value %h end_offset %0d",
					results_seen, value, end_offset);
			end
		end else begin
			exp = parse_results_due.pop_front();
			if (value !== exp.value || end_offset !== exp.offset
					|| range_error !== exp.range_err) begin
				err_count++;
				if (err_count <= REPORT_LIMIT) begin
					$display("result %0d mismatch: value %h / %h, end_offset %0d / %0d, %s%0d / %0d",
						results_seen, exp.value, value, exp.offset, end_offset,
						"range_error ", exp.range_err, range_error);
				end
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off that fills the block.
	initial begin
		pop  <= 1'b0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_result();
			end
			if (!held && results_seen >= HOLD_AT_RESULT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus: reset, directed strings, random phases.
	initial begin
		int sent;
		int n;
		arst_n        <= 1'b0;
		push          <= 1'b0;
		char_code     <= '0;
		radix         <= '0;
		unsigned_mode <= 1'b0;
		last          <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		results_seen   = 0;
		err_count      = 0;
		clear_scan();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			send_byte(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].rdx, DIRECTED_ROWS[i].uns,
				DIRECTED_ROWS[i].lst, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
		end

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				send_string(n);
				sent += n;
			end
		end
		push <= 1'b0;

		while (parse_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/ttip_pkg.sv
design/ttip_front.sv
design/ttip_queue.sv
design/ttip_back.sv
design/text_to_integer_parser.sv
sim/tb_top.sv
